/* rtl/core/rctc_pkg.sv */
package rctc_pkg;

    localparam int MaxSources = 16;
    localparam int IdxW       = (MaxSources > 1) ? $clog2(MaxSources) : 1;
    localparam int CntW       = $clog2(MaxSources + 1);
    localparam int FieldW     = 16;
    localparam int StatusW    = 3;
    localparam int SlotW      = 4;

    typedef enum logic [StatusW-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_ADDED     = 3'd1,
        ST_STALE_RST = 3'd2,
        ST_STALE_MSG = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_APPEND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FieldW-1:0] addr;
        logic [FieldW-1:0] rst_cnt;
        logic [FieldW-1:0] msg_cnt;
    } entry_t;

endpackage

/* rtl/core/rctc_ram.sv */
module rctc_ram #(
    parameter int Width = 48,
    parameter int Depth = 16,
    localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AddrBits-1:0]      waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [AddrBits-1:0]      raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/replay_counter_table_check_top.sv */
// ch  dir  fields                                                        handshake
// s_  in   s_source_address s_sender_reset_count s_sender_message_count  s_valid/s_ready
// m_  out  m_status m_persist m_slot                                     m_valid/m_ready
//
// one slot compared per cycle on the single ram read port; a match ends the scan,
// a miss on the last used slot (or an empty table) goes on to the append state
// before the result is registered; s_ready returns with m_valid
// aresetn is synchronous, active low, and empties the table at once
// a held result does not stop the next item being taken and scanned
// a stalled output only holds the finished item until the register frees
module replay_counter_table_check_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rctc_pkg::FieldW-1:0]  s_source_address,
    input  logic [rctc_pkg::FieldW-1:0]  s_sender_reset_count,
    input  logic [rctc_pkg::FieldW-1:0]  s_sender_message_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rctc_pkg::StatusW-1:0] m_status,
    output logic                         m_persist,
    output logic [rctc_pkg::SlotW-1:0]   m_slot
);

    rctc_pkg::state_t  state_reg, state_next;
    logic [rctc_pkg::IdxW-1:0] idx_reg, idx_next;
    logic [rctc_pkg::CntW-1:0] used_reg, used_next;
    rctc_pkg::entry_t  item_reg, item_next;
    rctc_pkg::status_t res_status_reg, res_status_next;
    logic              res_persist_reg, res_persist_next;
    logic [rctc_pkg::SlotW-1:0] res_slot_reg, res_slot_next;
    logic              m_valid_reg, m_valid_next;
    rctc_pkg::status_t m_status_reg, m_status_next;
    logic              m_persist_reg, m_persist_next;
    logic [rctc_pkg::SlotW-1:0] m_slot_reg, m_slot_next;

    logic                      ram_we;
    logic [rctc_pkg::IdxW-1:0] ram_waddr;
    logic [rctc_pkg::IdxW-1:0] ram_raddr;
    logic [$bits(rctc_pkg::entry_t)-1:0] ram_rdata;
    rctc_pkg::entry_t          known;

    logic accept;
    logic out_free;
    logic hit;
    logic last;
    logic full;
    logic [rctc_pkg::IdxW-1:0] idx_inc;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign known    = rctc_pkg::entry_t'(ram_rdata);
    assign hit      = known.addr == item_reg.addr;
    assign idx_inc  = idx_reg + rctc_pkg::IdxW'(1);
    assign last     = (rctc_pkg::CntW'(idx_reg) + rctc_pkg::CntW'(1)) == used_reg;
    assign full     = used_reg == rctc_pkg::CntW'(rctc_pkg::MaxSources);

    rctc_ram #(
        .Width($bits(rctc_pkg::entry_t)),
        .Depth(rctc_pkg::MaxSources)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(item_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rctc_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (used_reg == '0) ? rctc_pkg::S_APPEND : rctc_pkg::S_CHECK;
                end
            end
            rctc_pkg::S_CHECK: begin
                if (hit) begin
                    state_next = rctc_pkg::S_DONE;
                end else if (last) begin
                    state_next = rctc_pkg::S_APPEND;
                end
            end
            rctc_pkg::S_APPEND: state_next = rctc_pkg::S_DONE;
            rctc_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = rctc_pkg::S_IDLE;
                end
            end
            default: state_next = rctc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready          = state_reg == rctc_pkg::S_IDLE;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_raddr        = (state_reg == rctc_pkg::S_IDLE) ? '0 : idx_inc;
        idx_next         = idx_reg;
        used_next        = used_reg;
        item_next        = item_reg;
        res_status_next  = res_status_reg;
        res_persist_next = res_persist_reg;
        res_slot_next    = res_slot_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_persist_next   = m_persist_reg;
        m_slot_next      = m_slot_reg;
        case (state_reg)
            rctc_pkg::S_IDLE: begin
                if (accept) begin
                    item_next.addr    = s_source_address;
                    item_next.rst_cnt = s_sender_reset_count;
                    item_next.msg_cnt = s_sender_message_count;
                    idx_next          = '0;
                end
            end
            rctc_pkg::S_CHECK: begin
                res_slot_next    = rctc_pkg::SlotW'(idx_reg);
                res_persist_next = 1'b0;
                if (hit) begin
                    if (known.rst_cnt < item_reg.rst_cnt) begin
                        ram_we           = 1'b1;
                        res_status_next  = rctc_pkg::ST_ACCEPTED;
                        res_persist_next = 1'b1;
                    end else if (known.rst_cnt != item_reg.rst_cnt) begin
                        res_status_next = rctc_pkg::ST_STALE_RST;
                    end else if (known.msg_cnt < item_reg.msg_cnt) begin
                        ram_we          = 1'b1;
                        res_status_next = rctc_pkg::ST_ACCEPTED;
                    end else begin
                        res_status_next = rctc_pkg::ST_STALE_MSG;
                    end
                end else begin
                    idx_next = idx_inc;
                end
            end
            rctc_pkg::S_APPEND: begin
                ram_waddr = used_reg[rctc_pkg::IdxW-1:0];
                if (full) begin
                    res_status_next  = rctc_pkg::ST_FULL;
                    res_persist_next = 1'b0;
                    res_slot_next    = '0;
                end else begin
                    ram_we           = 1'b1;
                    used_next        = used_reg + rctc_pkg::CntW'(1);
                    res_status_next  = rctc_pkg::ST_ADDED;
                    res_persist_next = 1'b1;
                    res_slot_next    = rctc_pkg::SlotW'(used_reg[rctc_pkg::IdxW-1:0]);
                end
            end
            rctc_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_persist_next = res_persist_reg;
                    m_slot_next    = res_slot_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rctc_pkg::S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg         <= idx_next;
        item_reg        <= item_next;
        res_status_reg  <= res_status_next;
        res_persist_reg <= res_persist_next;
        res_slot_reg    <= res_slot_next;
        m_status_reg    <= m_status_next;
        m_persist_reg   <= m_persist_next;
        m_slot_reg      <= m_slot_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_persist = m_persist_reg;
    assign m_slot    = m_slot_reg;

endmodule

/* rtl/core/rctc_checker.sv */
module rctc_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [rctc_pkg::StatusW-1:0] m_status,
    input  logic                         m_persist,
    input  logic [rctc_pkg::SlotW-1:0]   m_slot
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_persist)
            && $stable(m_slot))
        else $error("result changed while stalled");

    // one item scanned at a time: busy after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_added: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rctc_pkg::ST_ADDED |-> m_persist)
        else $error("new source without persist");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rctc_pkg::ST_FULL |-> !m_persist && m_slot == '0)
        else $error("table full with persist or slot set");

    a_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == rctc_pkg::ST_STALE_RST || m_status == rctc_pkg::ST_STALE_MSG)
            |-> !m_persist)
        else $error("stale result with persist");

endmodule

bind replay_counter_table_check_top rctc_checker u_rctc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_status(m_status),
    .m_persist(m_persist),
    .m_slot  (m_slot)
);

/* sim/replay_verdict_check.sv */
`timescale 1ns / 1ps

module replay_verdict_check (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [rctc_pkg::FieldW-1:0]  s_source_address,
    input  logic [rctc_pkg::FieldW-1:0]  s_sender_reset_count,
    input  logic [rctc_pkg::FieldW-1:0]  s_sender_message_count,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [rctc_pkg::StatusW-1:0] m_status,
    input  logic                         m_persist,
    input  logic [rctc_pkg::SlotW-1:0]   m_slot,
    output int                           mismatches,
    output int                           outstanding
);

    typedef struct packed {
        rctc_pkg::status_t          status;
        logic                       persist;
        logic [rctc_pkg::SlotW-1:0] slot;
    } verdict_t;

    logic [rctc_pkg::FieldW-1:0] tab_addr [rctc_pkg::MaxSources];
    logic [rctc_pkg::FieldW-1:0] tab_rst  [rctc_pkg::MaxSources];
    logic [rctc_pkg::FieldW-1:0] tab_msg  [rctc_pkg::MaxSources];
    int                slots_filled   = 0;
    int                mismatch_count = 0;
    int                due_count      = 0;
    verdict_t          verdicts_due [$];

    assign mismatches  = mismatch_count;
    assign outstanding = due_count;

    function automatic verdict_t predict_verdict(input logic [rctc_pkg::FieldW-1:0] a,
                                                 input logic [rctc_pkg::FieldW-1:0] r,
                                                 input logic [rctc_pkg::FieldW-1:0] m);
        verdict_t v;
        bit       hit;
        hit       = 1'b0;
        v.status  = rctc_pkg::ST_FULL;
        v.persist = 1'b0;
        v.slot    = '0;
        for (int i = 0; i < slots_filled && !hit; i++) begin
            if (tab_addr[i] == a) begin
                hit    = 1'b1;
                v.slot = rctc_pkg::SlotW'(i);
                if (tab_rst[i] < r) begin
                    tab_rst[i] = r;
                    tab_msg[i] = m;
                    v.status   = rctc_pkg::ST_ACCEPTED;
                    v.persist  = 1'b1;
                end else if (tab_rst[i] != r) begin
                    v.status = rctc_pkg::ST_STALE_RST;
                end else if (tab_msg[i] < m) begin
                    tab_msg[i] = m;
                    v.status   = rctc_pkg::ST_ACCEPTED;
                end else begin
                    v.status = rctc_pkg::ST_STALE_MSG;
                end
            end
        end
        if (!hit && slots_filled < rctc_pkg::MaxSources) begin
            tab_addr[slots_filled] = a;
            tab_rst[slots_filled]  = r;
            tab_msg[slots_filled]  = m;
            v.status               = rctc_pkg::ST_ADDED;
            v.persist              = 1'b1;
            v.slot                 = rctc_pkg::SlotW'(slots_filled);
            slots_filled++;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        verdict_t want;
        if (!aresetn) begin
            slots_filled = 0;
            verdicts_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result transfer with nothing due");
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch($sformatf("status %0d, wanted %0d", m_status,
                                                want.status));
                    if (m_persist !== want.persist)
                        flag_mismatch($sformatf("persist %0b, wanted %0b", m_persist,
                                                want.persist));
                    if (m_slot !== want.slot)
                        flag_mismatch($sformatf("slot %0d, wanted %0d", m_slot, want.slot));
                end
            end
            if (s_valid && s_ready)
                verdicts_due.push_back(predict_verdict(s_source_address,
                                                       s_sender_reset_count,
                                                       s_sender_message_count));
        end
        due_count = verdicts_due.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CycleLimit = 500000;
    localparam int HoldCycles = 200;

    logic                         aclk                   = 1'b0;
    logic                         aresetn                = 1'b0;
    logic                         s_valid                = 1'b0;
    logic                         s_ready;
    logic [rctc_pkg::FieldW-1:0]  s_source_address       = '0;
    logic [rctc_pkg::FieldW-1:0]  s_sender_reset_count   = '0;
    logic [rctc_pkg::FieldW-1:0]  s_sender_message_count = '0;
    logic                         m_valid;
    logic                         m_ready                = 1'b0;
    logic [rctc_pkg::StatusW-1:0] m_status;
    logic                         m_persist;
    logic [rctc_pkg::SlotW-1:0]   m_slot;

    int mismatches;
    int outstanding;
    int cycles     = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    // sources that end up in the table, with the counters last stored for each
    logic [rctc_pkg::FieldW-1:0] pool      [rctc_pkg::MaxSources];
    logic [rctc_pkg::FieldW-1:0] last_rst  [rctc_pkg::MaxSources];
    logic [rctc_pkg::FieldW-1:0] last_msg  [rctc_pkg::MaxSources];
    bit                          pool_used [rctc_pkg::MaxSources];

    replay_counter_table_check_top dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_source_address       (s_source_address),
        .s_sender_reset_count   (s_sender_reset_count),
        .s_sender_message_count (s_sender_message_count),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_persist              (m_persist),
        .m_slot                 (m_slot)
    );

    replay_verdict_check checker_i (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_source_address       (s_source_address),
        .s_sender_reset_count   (s_sender_reset_count),
        .s_sender_message_count (s_sender_message_count),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_persist              (m_persist),
        .m_slot                 (m_slot),
        .mismatches             (mismatches),
        .outstanding            (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic bit in_pool(input logic [rctc_pkg::FieldW-1:0] a, input int upto);
        bit found;
        found = 1'b0;
        for (int k = 0; k < upto; k++)
            if (pool[k] == a)
                found = 1'b1;
        return found;
    endfunction

    function automatic void note_offer(input logic [rctc_pkg::FieldW-1:0] a,
                                       input logic [rctc_pkg::FieldW-1:0] r,
                                       input logic [rctc_pkg::FieldW-1:0] m);
        for (int k = 0; k < rctc_pkg::MaxSources; k++) begin
            if (pool[k] == a) begin
                if (!pool_used[k]) begin
                    pool_used[k] = 1'b1;
                    last_rst[k]  = r;
                    last_msg[k]  = m;
                end else if (r > last_rst[k]) begin
                    last_rst[k] = r;
                    last_msg[k] = m;
                end else if (r == last_rst[k] && m > last_msg[k]) begin
                    last_msg[k] = m;
                end
            end
        end
    endfunction

    task automatic send_item(input logic [rctc_pkg::FieldW-1:0] a,
                             input logic [rctc_pkg::FieldW-1:0] r,
                             input logic [rctc_pkg::FieldW-1:0] m);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid                <= 1'b1;
        s_source_address       <= a;
        s_sender_reset_count   <= r;
        s_sender_message_count <= m;
        note_offer(a, r, m);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [rctc_pkg::FieldW-1:0] fresh_address();
        logic [rctc_pkg::FieldW-1:0] a;
        do a = rctc_pkg::FieldW'($urandom); while (in_pool(a, rctc_pkg::MaxSources));
        return a;
    endfunction

    task automatic send_random();
        int unsigned                 roll;
        int                          k;
        int                          hi;
        logic [rctc_pkg::FieldW-1:0] a;
        logic [rctc_pkg::FieldW-1:0] r;
        logic [rctc_pkg::FieldW-1:0] m;
        roll = $urandom_range(99);
        k    = $urandom_range(rctc_pkg::MaxSources - 1);
        a    = pool[k];
        r    = last_rst[k];
        m    = last_msg[k];
        if (roll < 10) begin
            a = fresh_address();
            r = rctc_pkg::FieldW'($urandom);
            m = rctc_pkg::FieldW'($urandom);
        end else if (roll < 70) begin
            if (last_msg[k] == '1) begin
                m = rctc_pkg::FieldW'($urandom);
            end else if ($urandom_range(15) == 0) begin
                m = rctc_pkg::FieldW'($urandom_range(65535, int'(last_msg[k]) + 1));
            end else begin
                hi = int'(last_msg[k]) + 20;
                if (hi > 65535)
                    hi = 65535;
                m = rctc_pkg::FieldW'($urandom_range(hi, int'(last_msg[k]) + 1));
            end
        end else if (roll < 85) begin
            if (last_rst[k] != '1) begin
                if ($urandom_range(15) == 0) begin
                    r = rctc_pkg::FieldW'($urandom_range(65535, int'(last_rst[k]) + 1));
                end else begin
                    hi = int'(last_rst[k]) + 4;
                    if (hi > 65535)
                        hi = 65535;
                    r = rctc_pkg::FieldW'($urandom_range(hi, int'(last_rst[k]) + 1));
                end
            end
            m = ($urandom_range(3) == 0) ? rctc_pkg::FieldW'($urandom)
                                         : rctc_pkg::FieldW'($urandom_range(255));
        end else if (roll < 92 && last_rst[k] != '0) begin
            r = rctc_pkg::FieldW'($urandom_range(int'(last_rst[k]) - 1, 0));
            m = rctc_pkg::FieldW'($urandom);
        end else begin
            m = rctc_pkg::FieldW'($urandom_range(int'(last_msg[k]), 0));
        end
        send_item(a, r, m);
    endtask

    initial begin : stimulus
        logic [rctc_pkg::FieldW-1:0] a;
        int                          idle_set  [4];
        int                          stall_set [4];
        idle_set  = '{0, 50, 0, 30};
        stall_set = '{0, 0, 50, 30};

        pool[0] = '0;
        pool[1] = '1;
        for (int k = 2; k < rctc_pkg::MaxSources; k++) begin
            do a = rctc_pkg::FieldW'($urandom); while (in_pool(a, k));
            pool[k] = a;
        end
        for (int k = 0; k < rctc_pkg::MaxSources; k++)
            pool_used[k] = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'hFFFF);
        send_item(16'h0000, 16'h0000, 16'hFFFF);
        send_item(16'h0000, 16'h0001, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'h0005);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'hFFFF, 16'hFFFE, 16'h0000);
        for (int k = 2; k < rctc_pkg::MaxSources; k++)
            send_item(pool[k], rctc_pkg::FieldW'($urandom_range(1000)),
                      rctc_pkg::FieldW'($urandom_range(1000)));
        send_item(fresh_address(), 16'hFFFF, 16'h0000);
        send_item(pool[rctc_pkg::MaxSources-1], last_rst[rctc_pkg::MaxSources-1],
                  last_msg[rctc_pkg::MaxSources-1] + rctc_pkg::FieldW'(1));
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle  = idle_set[p];
            recv_stall = stall_set[p];
            repeat (240) send_random();
            wait_drained();
        end

        // long receiver hold-off while items keep coming
        send_idle  = 0;
        recv_stall = 0;
        hold_token++;
        repeat (24) send_random();
        wait_drained();

        repeat (rctc_pkg::MaxSources + 10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rctc_pkg.sv
rtl/core/rctc_ram.sv
rtl/core/replay_counter_table_check_top.sv
rtl/core/rctc_checker.sv
sim/replay_verdict_check.sv
sim/tb_top.sv
